@@ design/cipu_pkg.sv @@
// Shared types and codes for the CPU image pixel unpacker.
// No dependencies; used by every cipu_* module and the top level.
package cipu_pkg;

   localparam int AddrWidth = 5;

   // Command codes carried in the request transaction.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // Pixel format codes.
   localparam logic [1:0] FMT_8BPP  = 2'd0;
   localparam logic [1:0] FMT_16BPP = 2'd1;
   localparam logic [1:0] FMT_32BPP = 2'd2;
   localparam logic [1:0] FMT_NONE  = 2'd3;

   // Register indexes (byte address = 4 * index).
   localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] REG_OUT_WIDTH    = 3'd2;
   localparam logic [2:0] REG_IN_WIDTH     = 3'd3;
   localparam logic [2:0] REG_PIXEL_FORMAT = 3'd4;

   localparam logic [1:0] LAST_SLOT_8BPP  = 2'd3;
   localparam logic [1:0] LAST_SLOT_16BPP = 2'd1;

   typedef struct packed {
      logic        cmd;
      logic [31:0] data_word;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [31:0] pixel_value;
      logic        write_enable;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] out_width;
      logic [15:0] in_width;
      logic [1:0]  pixel_format;
   } config_type;

   // Current slot presented by the slicer to the rest of the block.
   typedef struct packed {
      logic        active;   // a transaction is held
      logic        start;    // held transaction is a start command
      logic        emit;     // held transaction produces a pixel this slot
      logic        last;     // this slot is the final one of the word
      logic [31:0] value;    // unpacked pixel value
   } slot_type;

endpackage

@@ design/cipu_csr.sv @@
// Configuration register file with APB-style access.
// Depends on cipu_pkg.
module cipu_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cipu_pkg::AddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output cipu_pkg::config_type             cfg
);

   cipu_pkg::config_type cfg_ff, cfg_in;
   logic [2:0] index;
   logic       wr;

   assign index      = csr_paddr[cipu_pkg::AddrWidth-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (index)
            cipu_pkg::REG_ORIGIN_X:     cfg_in.origin_x     = csr_pwdata[15:0];
            cipu_pkg::REG_ORIGIN_Y:     cfg_in.origin_y     = csr_pwdata[15:0];
            cipu_pkg::REG_OUT_WIDTH:    cfg_in.out_width    = csr_pwdata[15:0];
            cipu_pkg::REG_IN_WIDTH:     cfg_in.in_width     = csr_pwdata[15:0];
            cipu_pkg::REG_PIXEL_FORMAT: cfg_in.pixel_format = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         cipu_pkg::REG_ORIGIN_X:     csr_prdata = {16'd0, cfg_ff.origin_x};
         cipu_pkg::REG_ORIGIN_Y:     csr_prdata = {16'd0, cfg_ff.origin_y};
         cipu_pkg::REG_OUT_WIDTH:    csr_prdata = {16'd0, cfg_ff.out_width};
         cipu_pkg::REG_IN_WIDTH:     csr_prdata = {16'd0, cfg_ff.in_width};
         cipu_pkg::REG_PIXEL_FORMAT: csr_prdata = {30'd0, cfg_ff.pixel_format};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/cipu_slicer.sv @@
// Input register and slot counter: splits a held data word into pixel slots.
// Depends on cipu_pkg.
module cipu_slicer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cipu_pkg::req_type     req_data,
   input  logic [1:0]            pixel_format,
   input  logic                  out_free,   // result register can load this cycle
   output cipu_pkg::slot_type    slot,
   output logic                  fire        // held slot is processed this cycle
);

   logic        hold_valid_ff, hold_valid_in;
   logic        hold_cmd_ff, hold_cmd_in;
   logic [31:0] hold_word_ff, hold_word_in;
   logic [1:0]  slot_ff, slot_in;
   logic        consume;

   always_comb begin
      slot.active = hold_valid_ff;
      slot.start  = hold_valid_ff && (hold_cmd_ff == cipu_pkg::CMD_START);
      slot.emit   = hold_valid_ff && (hold_cmd_ff == cipu_pkg::CMD_DATA)
                    && (pixel_format != cipu_pkg::FMT_NONE);
      case (pixel_format)
         cipu_pkg::FMT_8BPP: begin
            slot.value = {24'd0, hold_word_ff[8*slot_ff +: 8]};
            slot.last  = (slot_ff == cipu_pkg::LAST_SLOT_8BPP);
         end
         cipu_pkg::FMT_16BPP: begin
            slot.value = {16'd0, hold_word_ff[16*slot_ff[0] +: 16]};
            slot.last  = (slot_ff[0] == cipu_pkg::LAST_SLOT_16BPP[0]);
         end
         default: begin
            slot.value = hold_word_ff;
            slot.last  = 1'b1;
         end
      endcase
   end

   assign fire      = hold_valid_ff && out_free;
   assign consume   = slot.start || !slot.emit || slot.last;
   assign req_stall = hold_valid_ff && !(fire && consume);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      hold_word_in  = hold_word_ff;
      slot_in       = slot_ff;
      if (!req_stall) begin
         hold_valid_in = req_valid;
         hold_cmd_in   = req_data.cmd;
         hold_word_in  = req_data.data_word;
         slot_in       = 2'd0;
      end else if (fire) begin
         slot_in = slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         slot_ff       <= 2'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         slot_ff       <= slot_in;
      end
      hold_cmd_ff  <= hold_cmd_in;
      hold_word_ff <= hold_word_in;
   end

endmodule

@@ design/cipu_position.sv @@
// Raster position tracker: current column/row, clip test and line wrap.
// Depends on cipu_pkg.
module cipu_position (
   input  logic                  clock,
   input  logic                  reset,
   input  cipu_pkg::config_type  cfg,
   input  cipu_pkg::slot_type    slot,
   input  logic                  fire,
   output logic [15:0]           pixel_x,
   output logic [15:0]           pixel_y,
   output logic                  write_enable
);

   logic [15:0] cur_x_ff, cur_x_in;
   logic [15:0] cur_y_ff, cur_y_in;
   logic [15:0] next_x, clip_x, rel_x;
   logic        wrap;

   assign clip_x       = cfg.origin_x + cfg.out_width;
   assign write_enable = cur_x_ff < clip_x;
   assign pixel_x      = cur_x_ff;
   assign pixel_y      = cur_y_ff;

   // Left of the origin the distance is huge, so the row always wraps.
   assign next_x = cur_x_ff + 16'd1;
   assign rel_x  = next_x - cfg.origin_x;
   assign wrap   = (next_x < cfg.origin_x) || (rel_x >= cfg.in_width);

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (fire && slot.start) begin
         cur_x_in = cfg.origin_x;
         cur_y_in = cfg.origin_y;
      end else if (fire && slot.emit) begin
         if (wrap) begin
            cur_x_in = cfg.origin_x;
            cur_y_in = cur_y_ff + 16'd1;
         end else begin
            cur_x_in = next_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= 16'd0;
         cur_y_ff <= 16'd0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

endmodule

@@ design/cpu_image_pixel_unpacker.sv @@
// Top level of the CPU image pixel unpacker: registers, slicer, position, result register.
// Depends on cipu_pkg, cipu_csr, cipu_slicer and cipu_position.
//
// Usage:
//  - req channel (valid/stall): one transaction is a start command (cmd 0), which
//    moves the position to (origin_x, origin_y), or a 32-bit data word (cmd 1).
//  - rsp channel (valid/stall): one transaction per pixel slot, with column, row,
//    value, write enable (clip test) and a last flag on the word's final slot.
//  - csr port: APB-style, registers at byte addresses 0,4,8,12,16; write only
//    while the block is idle. pready is tied high.
// Timing:
//  - An accepted transaction sits in the input register, from which its pixels pass
//    to the rsp register, one pixel per cycle while rsp is not stalled.
//  - A data word is cut into 4 slots at 8 bpp, 2 at 16 bpp and 1 at 32 bpp;
//    start commands and words in the unsupported format take a single slot and
//    give no pixel. The next transaction is taken in the cycle the last slot
//    leaves.
//  - A stalled result holds in the rsp register and freezes the slicer, which in
//    turn stalls req once its input register is full.
// Reset clears the registers, the position and both valid flags.
module cpu_image_pixel_unpacker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cipu_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cipu_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cipu_pkg::AddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   cipu_pkg::config_type cfg;
   cipu_pkg::slot_type   slot;
   cipu_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free, fire, out_load;
   logic [15:0]          pos_x, pos_y;
   logic                 pos_we;

   cipu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Result register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   cipu_slicer u_slicer (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .pixel_format (cfg.pixel_format),
      .out_free     (out_free),
      .slot         (slot),
      .fire         (fire)
   );

   cipu_position u_position (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .slot         (slot),
      .fire         (fire),
      .pixel_x      (pos_x),
      .pixel_y      (pos_y),
      .write_enable (pos_we)
   );

   assign out_load = fire && slot.emit;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.pixel_x      = pos_x;
         rsp_data_in.pixel_y      = pos_y;
         rsp_data_in.pixel_value  = slot.value;
         rsp_data_in.write_enable = pos_we;
         rsp_data_in.last         = slot.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A stalled result is never overwritten by a new pixel.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("result register overwritten while stalled");

   // Pixels come only from data words in a supported format.
   a_emit_format: assert property (@(posedge clock) disable iff (reset)
      slot.emit |-> (cfg.pixel_format != cipu_pkg::FMT_NONE) && !slot.start)
      else $error("pixel slot from start command or unsupported format");

   // Input is taken only when the held transaction is done or absent.
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && slot.active) |-> fire)
      else $error("new transaction accepted over a busy input register");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for cpu_image_pixel_unpacker.
// Depends on cipu_pkg and the RTL top level. Holds a scoreboard class with its own
// unpacker state, plain tasks for the req and csr ports and a checker for rsp.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Generous: far above the length of the slowest correct run.
   localparam int CycleLimit = 200000;
   // Cycles allowed for a start or an unsupported word to drain after the
   // last pixel has arrived.
   localparam int SettleCycles = 8;

   // Tracks image position and clip settings, and queues the pixel slots
   // that each accepted request transaction must produce.
   class unpack_tracker;
      logic [15:0]       origin_x, origin_y, out_width, in_width;
      logic [1:0]        pixel_format;
      logic [15:0]       col, row;
      cipu_pkg::rsp_type pending_pixels[$];
      int                failures;

      function new();
         origin_x = '0;
         origin_y = '0;
         out_width = '0;
         in_width = '0;
         pixel_format = cipu_pkg::FMT_8BPP;
         col = '0;
         row = '0;
         failures = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] value);
         case (index)
            cipu_pkg::REG_ORIGIN_X:     origin_x = value[15:0];
            cipu_pkg::REG_ORIGIN_Y:     origin_y = value[15:0];
            cipu_pkg::REG_OUT_WIDTH:    out_width = value[15:0];
            cipu_pkg::REG_IN_WIDTH:     in_width = value[15:0];
            cipu_pkg::REG_PIXEL_FORMAT: pixel_format = value[1:0];
            default: ;
         endcase
      endfunction

      // One slot at the current position, then step the column and wrap the row.
      function void queue_slot(logic [31:0] value, logic last_slot);
         cipu_pkg::rsp_type px;
         logic [15:0]       clip;
         logic [31:0]       rel;
         clip = origin_x + out_width;
         px.pixel_x = col;
         px.pixel_y = row;
         px.pixel_value = value;
         px.write_enable = (col < clip);
         px.last = last_slot;
         pending_pixels.push_back(px);
         col = col + 16'd1;
         // unsigned 32-bit distance: a column left of the origin wraps at once
         rel = {16'd0, col} - {16'd0, origin_x};
         if (rel >= {16'd0, in_width}) begin
            col = origin_x;
            row = row + 16'd1;
         end
      endfunction

      function void note_request(cipu_pkg::req_type r);
         int i;
         if (r.cmd == cipu_pkg::CMD_START) begin
            col = origin_x;
            row = origin_y;
            return;
         end
         case (pixel_format)
            cipu_pkg::FMT_8BPP: begin
               for (i = 0; i < 4; i++)
                  queue_slot({24'd0, r.data_word[8*i +: 8]}, i == 3);
            end
            cipu_pkg::FMT_16BPP: begin
               queue_slot({16'd0, r.data_word[15:0]}, 1'b0);
               queue_slot({16'd0, r.data_word[31:16]}, 1'b1);
            end
            cipu_pkg::FMT_32BPP: queue_slot(r.data_word, 1'b1);
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_pixel(cipu_pkg::rsp_type got);
         cipu_pkg::rsp_type want;
         if (pending_pixels.size() == 0) begin
            $display("%0t: pixel with none pending, expected nothing, actual %h",
                     $time, got);
            failures++;
            return;
         end
         want = pending_pixels.pop_front();
         compare_field("pixel_x", {16'd0, want.pixel_x}, {16'd0, got.pixel_x});
         compare_field("pixel_y", {16'd0, want.pixel_y}, {16'd0, got.pixel_y});
         compare_field("pixel_value", want.pixel_value, got.pixel_value);
         compare_field("write_enable", {31'd0, want.write_enable},
                       {31'd0, got.write_enable});
         compare_field("last", {31'd0, want.last}, {31'd0, got.last});
      endfunction
   endclass

   // Every input starts at a known value; reset is high from time zero.
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   cipu_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   cipu_pkg::rsp_type               rsp_data;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [cipu_pkg::AddrWidth-1:0]  csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   unpack_tracker tracker;
   int            idle_pct = 16;   // chance, in percent, that a side idles this cycle
   int            cycles = 0;

   cpu_image_pixel_unpacker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL cpu_image_pixel_unpacker");
         $finish;
      end
   end

   // Result side: values read here are the ones from before this edge, so a
   // transaction is taken exactly when valid was high and stall was low.
   // The stall for the next cycle is then drawn at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_pixel(rsp_data);
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // Offers one request transaction, after a random number of idle cycles, and
   // returns at the edge where it is accepted. Valid stays high on return so
   // back-to-back transactions need no second assignment in the same step.
   task automatic send_request(input cipu_pkg::req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
   endtask

   task automatic send_start();
      cipu_pkg::req_type r;
      r.cmd = cipu_pkg::CMD_START;
      r.data_word = $urandom;   // ignored by the block, but keeps the bits moving
      send_request(r);
   endtask

   task automatic send_word(input logic [31:0] word);
      cipu_pkg::req_type r;
      r.cmd = cipu_pkg::CMD_DATA;
      r.data_word = word;
      send_request(r);
   endtask

   // Drops valid, waits for every pending pixel, then lets any start or
   // unsupported word still inside the block drain before registers change.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Setup cycle, access cycle (register written at that edge), then psel low
   // before return, so back-to-back writes never collide in one step.
   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      tracker.write_reg(index, value);
      @(posedge clock);
   endtask

   task automatic load_image_regs(input logic [15:0] ox, input logic [15:0] oy,
                                  input logic [15:0] ow, input logic [15:0] iw,
                                  input logic [1:0] fmt);
      // upper bits of pwdata carry noise; only the low field bits count
      write_csr(cipu_pkg::REG_ORIGIN_X, {16'($urandom), ox});
      write_csr(cipu_pkg::REG_ORIGIN_Y, {16'($urandom), oy});
      write_csr(cipu_pkg::REG_OUT_WIDTH, {16'($urandom), ow});
      write_csr(cipu_pkg::REG_IN_WIDTH, {16'($urandom), iw});
      write_csr(cipu_pkg::REG_PIXEL_FORMAT, {30'($urandom), fmt});
   endtask

   // Origins anywhere; widths mostly small so rows wrap and clip often.
   function automatic logic [15:0] pick_origin();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_width();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(1, 9));
      endcase
   endfunction

   function automatic logic [1:0] pick_format();
      if ($urandom_range(0, 9) == 0)
         return cipu_pkg::FMT_NONE;
      return 2'($urandom_range(0, 2));
   endfunction

   initial begin
      int phase;
      int k;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // Registers at reset: zero widths, so each slot ends its row and none is written.
      send_word(32'hFFFF_FFFF);

      // Small image at (10,20): clip at column 15, wrap after 6 columns.
      wait_idle();
      load_image_regs(16'd10, 16'd20, 16'd5, 16'd6, cipu_pkg::FMT_8BPP);
      send_start();
      send_word(32'h0403_0201);
      send_word(32'h80FF_7F00);

      // Halfword pixels, extremes of each half.
      wait_idle();
      write_csr(cipu_pkg::REG_PIXEL_FORMAT, {30'd0, cipu_pkg::FMT_16BPP});
      send_word(32'hFFFF_0000);
      send_word(32'h0001_8000);

      // Full-word pixels.
      wait_idle();
      write_csr(cipu_pkg::REG_PIXEL_FORMAT, {30'd0, cipu_pkg::FMT_32BPP});
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(32'h8000_0001);

      // Unsupported format: nothing comes out and the position must hold,
      // which the following full-word pixel shows.
      wait_idle();
      write_csr(cipu_pkg::REG_PIXEL_FORMAT, {30'd0, cipu_pkg::FMT_NONE});
      send_word(32'hDEAD_BEEF);
      wait_idle();
      write_csr(cipu_pkg::REG_PIXEL_FORMAT, {30'd0, cipu_pkg::FMT_32BPP});
      send_word(32'h1234_5678);

      // Column left of the origin: start at 0, then move the origin right.
      wait_idle();
      write_csr(cipu_pkg::REG_ORIGIN_X, 32'd0);
      send_start();
      wait_idle();
      write_csr(cipu_pkg::REG_ORIGIN_X, 32'd50);
      send_word(32'hCAFE_F00D);

      // Origin and width registers at their top values: column and row both wrap past 0xFFFF.
      wait_idle();
      load_image_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, cipu_pkg::FMT_8BPP);
      send_start();
      send_word(32'hA5A5_A5A5);
      send_word(32'h5A5A_5A5A);

      // Writes past the last register are ignored; the next word shows it.
      wait_idle();
      for (k = cipu_pkg::REG_PIXEL_FORMAT + 1; k < 8; k++)
         write_csr(3'(k), 32'hFFFF_FFFF);
      send_word(32'h0F0F_F0F0);

      // --- random part ---
      // Each phase is a fresh register set, a start, then mostly data words
      // with an occasional restart. Phase 3 runs with no idling on either side.
      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         idle_pct = (phase == 3) ? 0 : 16;
         load_image_regs(pick_origin(), pick_origin(), pick_width(), pick_width(),
                         pick_format());
         send_start();
         for (k = 0; k < 12; k++) begin
            if ($urandom_range(0, 99) < 12)
               send_start();
            else
               send_word($urandom);
         end
      end

      // Drain, then a short tail so a stray extra pixel would still be seen.
      wait_idle();
      idle_pct = 16;
      repeat (20) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_pixels.size() == 0)
         $display("PASS cpu_image_pixel_unpacker");
      else
         $display("FAIL cpu_image_pixel_unpacker");
      $finish;
   end

endmodule
